>>> hdl/pqa_pkg.sv
// Shared types, constants and helpers of the polygon area and angle qualifier.
package pqa_pkg;

   localparam int COORD_BITS_DEFAULT = 24;
   localparam int DIGIT_BITS         = 8;
   localparam int DIGIT_COUNT_BITS   = 4;
   localparam int SUM_BITS           = 60;
   localparam int AREA_BITS          = 56;
   localparam int CFG_AREA_BITS      = 32;
   localparam int CFG_COS_BITS       = 16;
   localparam int COS_SHIFT          = 16;
   localparam int CSR_DATA_BITS      = 32;
   localparam int CSR_INDEX_BITS     = 1;

   localparam logic [CFG_AREA_BITS-1:0] MIN_TWICE_AREA_RESET = 32'd40960;
   localparam logic [CFG_COS_BITS-1:0]  ANGLE_COS_SQ_RESET   = 16'd63559;

   localparam logic signed [SUM_BITS-1:0] SUM_MAX = {1'b0, {(SUM_BITS-1){1'b1}}};
   localparam logic signed [SUM_BITS-1:0] SUM_MIN = {1'b1, {(SUM_BITS-1){1'b0}}};
   localparam logic [AREA_BITS-1:0]       AREA_MAX = {AREA_BITS{1'b1}};

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_MIN_TWICE_AREA = 1'b0,
      CSR_ANGLE_COS_SQ   = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      REASON_KEPT  = 2'd0,
      REASON_AREA  = 2'd1,
      REASON_ANGLE = 2'd2
   } reason_type;

   typedef enum logic [1:0] {
      MUL_IDLE,
      MUL_RUN,
      MUL_ADD
   } mul_phase_type;

   typedef enum logic [2:0] {
      JOB_NONE,
      JOB_EDGE_IN,
      JOB_ANGLE_IN,
      JOB_EDGE_CLOSE,
      JOB_ANGLE_LAST,
      JOB_ANGLE_FIRST,
      JOB_END
   } job_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_SH,
      ST_SUM,
      ST_LA,
      ST_LB,
      ST_DOT,
      ST_DSQ,
      ST_LL,
      ST_RHS,
      ST_CMP,
      ST_FINISH
   } seq_state_type;

   typedef struct packed {
      logic                        start;
      logic                        clear;
      logic                        negate;
      logic [DIGIT_COUNT_BITS-1:0] digits;
   } mul_ctl_type;

   // job order for one vertex, given how many vertices came before it
   function automatic job_type next_job(input job_type job, input logic [1:0] count,
                                        input logic last);
      job_type nj;
      nj = JOB_END;
      case (job)
         JOB_NONE: begin
            if (count != 2'd0) nj = JOB_EDGE_IN;
            else if (last)     nj = JOB_EDGE_CLOSE;
         end
         JOB_EDGE_IN: begin
            if (count >= 2'd2) nj = JOB_ANGLE_IN;
            else if (last)     nj = JOB_EDGE_CLOSE;
         end
         JOB_ANGLE_IN: begin
            if (last) nj = JOB_EDGE_CLOSE;
         end
         JOB_EDGE_CLOSE: begin
            if (count != 2'd0) nj = JOB_ANGLE_LAST;
         end
         JOB_ANGLE_LAST:  nj = JOB_ANGLE_FIRST;
         default:         nj = JOB_END;
      endcase
      return nj;
   endfunction

endpackage

>>> hdl/pqa_mul.sv
// Shared digit-serial multiply-accumulate unit: acc = (clear ? 0 : acc) +/- a * b.
module pqa_mul #(
   parameter int WA = 100,
   parameter int WB = 50,
   parameter int AW = 118
) (
   input  logic                 clock,
   input  logic                 reset,
   input  pqa_pkg::mul_ctl_type ctl,
   input  logic [WA-1:0]        a,
   input  logic [WB-1:0]        b,
   output logic                 done,
   output logic signed [AW-1:0] acc
);

   localparam int DG   = pqa_pkg::DIGIT_BITS;
   localparam int ND   = (WB + DG - 1) / DG;
   localparam int IW   = (ND > 1) ? $clog2(ND) : 1;
   localparam int PADW = ND * DG;

   pqa_pkg::mul_phase_type phase_ff, phase_in;

   logic [WA-1:0]        a_ff;
   logic [DG-1:0]        dig_ff [ND];
   logic [IW-1:0]        cnt_ff;
   logic [AW-1:0]        prod_ff;
   logic [AW-1:0]        prod_in;
   logic                 clear_ff;
   logic                 negate_ff;
   logic signed [AW-1:0] acc_ff;
   logic [PADW-1:0]      b_pad;
   logic [WA+DG-1:0]     part;
   logic signed [AW-1:0] addend;
   logic signed [AW-1:0] base;

   assign b_pad = PADW'(b);

   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         pqa_pkg::MUL_IDLE: if (ctl.start) phase_in = pqa_pkg::MUL_RUN;
         pqa_pkg::MUL_RUN:  if (cnt_ff == '0) phase_in = pqa_pkg::MUL_ADD;
         pqa_pkg::MUL_ADD:  phase_in = pqa_pkg::MUL_IDLE;
         default:           phase_in = pqa_pkg::MUL_IDLE;
      endcase
   end

   always_comb begin
      done    = (phase_ff == pqa_pkg::MUL_ADD);
      part    = a_ff * dig_ff[cnt_ff];
      prod_in = (prod_ff << DG) + AW'(part);
      addend  = negate_ff ? -signed'(prod_ff) : signed'(prod_ff);
      base    = clear_ff ? '0 : acc_ff;
   end

   assign acc = acc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= pqa_pkg::MUL_IDLE;
      end else begin
         phase_ff <= phase_in;
      end
   end

   // most significant digit first
   always_ff @(posedge clock) begin
      unique case (phase_ff)
         pqa_pkg::MUL_IDLE: begin
            if (ctl.start) begin
               a_ff      <= a;
               for (int i = 0; i < ND; i++) dig_ff[i] <= b_pad[i*DG +: DG];
               cnt_ff    <= IW'(ctl.digits - 1'b1);
               prod_ff   <= '0;
               clear_ff  <= ctl.clear;
               negate_ff <= ctl.negate;
            end
         end
         pqa_pkg::MUL_RUN: begin
            prod_ff <= prod_in;
            cnt_ff  <= cnt_ff - 1'b1;
         end
         pqa_pkg::MUL_ADD: begin
            acc_ff <= base + addend;
         end
         default: ;
      endcase
   end

endmodule

>>> hdl/pqa_seq.sv
// Vertex store, job sequencer and verdict logic around the shared multiplier.
module pqa_seq #(
   parameter int COORD_BITS = pqa_pkg::COORD_BITS_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [COORD_BITS-1:0]           req_vertex_x,
   input  logic signed [COORD_BITS-1:0]           req_vertex_y,
   input  logic signed [COORD_BITS-1:0]           req_vertex_z,
   input  logic                                   req_last_vertex,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic                                   rsp_discard,
   output logic [1:0]                             rsp_discard_reason,
   output logic [pqa_pkg::AREA_BITS-1:0]          rsp_twice_area,
   input  logic [pqa_pkg::CFG_AREA_BITS-1:0]      min_twice_area,
   input  logic [pqa_pkg::CFG_COS_BITS-1:0]       angle_cos_sq
);

   localparam int C    = COORD_BITS;
   localparam int L    = 2 * C + 2;
   localparam int WA   = 2 * L;
   localparam int AW   = 2 * L + 18;
   localparam int DG   = pqa_pkg::DIGIT_BITS;
   localparam int SW   = pqa_pkg::SUM_BITS;
   localparam int NDC  = (C + DG - 1) / DG;
   localparam int NDL  = (L + DG - 1) / DG;
   localparam int NDK  = pqa_pkg::CFG_COS_BITS / DG;
   localparam int DCW  = pqa_pkg::DIGIT_COUNT_BITS;

   pqa_pkg::seq_state_type state_ff, state_in;
   pqa_pkg::job_type       job_ff, nj;
   pqa_pkg::mul_ctl_type   mctl;

   logic              issued_ff, issued_in;
   logic [1:0]        comp_ff, comp_in;
   logic [1:0]        count_ff;
   logic              last_ff;
   logic              sharp_ff;
   logic signed [SW-1:0] sum_ff;

   logic signed [C-1:0] cur_ff    [3];
   logic signed [C-1:0] first_ff  [3];
   logic signed [C-1:0] second_ff [3];
   logic signed [C-1:0] prev_ff   [3];
   logic signed [C-1:0] bprev_ff  [3];

   logic [L-1:0]   la_ff, lb_ff;
   logic [2*L-1:0] dsq_ff;

   logic                           rsp_valid_ff;
   logic                           rsp_discard_ff;
   logic [1:0]                     rsp_reason_ff;
   logic [pqa_pkg::AREA_BITS-1:0]  rsp_area_ff;

   logic [WA-1:0]        mul_a;
   logic [L-1:0]         mul_b;
   logic                 mul_done;
   logic signed [AW-1:0] acc;

   logic signed [C-1:0] p_sel [3];
   logic signed [C-1:0] c_sel [3];
   logic signed [C-1:0] n_sel [3];
   logic signed [C-1:0] ep    [3];
   logic signed [C-1:0] eq    [3];

   logic signed [C:0] da, db, uu, vv;
   logic [C-1:0]      da_mag, db_mag, u_mag, v_mag;
   logic              sh_neg;
   logic              step_done;
   logic              dot_pos;
   logic              accept;
   logic              rsp_free;

   logic signed [SW-1:0]  term_c;
   logic signed [SW:0]    sum_wide;
   logic signed [SW-1:0]  sum_new;
   logic [SW-1:0]         area_mag;
   pqa_pkg::reason_type   reason;
   logic [2*L+15:0]       lhs;
   logic                  sharp_now;

   pqa_mul #(.WA(WA), .WB(L), .AW(AW)) u_mul (
      .clock (clock),
      .reset (reset),
      .ctl   (mctl),
      .a     (mul_a),
      .b     (mul_b),
      .done  (mul_done),
      .acc   (acc)
   );

   assign accept    = (state_ff == pqa_pkg::ST_IDLE) && req_valid;
   assign step_done = issued_ff && mul_done;
   assign dot_pos   = !acc[AW-1] && (acc != '0);
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign nj        = pqa_pkg::next_job(job_ff, count_ff, last_ff);

   // vertex triple of the angle job, and the two ends of the edge job
   always_comb begin
      p_sel = bprev_ff;
      c_sel = prev_ff;
      n_sel = cur_ff;
      case (job_ff)
         pqa_pkg::JOB_ANGLE_LAST: begin
            p_sel = prev_ff;
            c_sel = cur_ff;
            n_sel = first_ff;
         end
         pqa_pkg::JOB_ANGLE_FIRST: begin
            p_sel = cur_ff;
            c_sel = first_ff;
            n_sel = (count_ff >= 2'd2) ? second_ff : cur_ff;
         end
         default: ;
      endcase
      ep = prev_ff;
      eq = cur_ff;
      if (job_ff == pqa_pkg::JOB_EDGE_CLOSE) begin
         ep = cur_ff;
         eq = first_ff;
      end
   end

   always_comb begin
      da     = {p_sel[comp_ff][C-1], p_sel[comp_ff]} - {c_sel[comp_ff][C-1], c_sel[comp_ff]};
      db     = {n_sel[comp_ff][C-1], n_sel[comp_ff]} - {c_sel[comp_ff][C-1], c_sel[comp_ff]};
      da_mag = da[C] ? C'(-da) : C'(da);
      db_mag = db[C] ? C'(-db) : C'(db);
      // term = px*qy - qx*py
      if (comp_ff == 2'd0) begin
         uu = {ep[0][C-1], ep[0]};
         vv = {eq[1][C-1], eq[1]};
      end else begin
         uu = {eq[0][C-1], eq[0]};
         vv = {ep[1][C-1], ep[1]};
      end
      u_mag  = uu[C] ? C'(-uu) : C'(uu);
      v_mag  = vv[C] ? C'(-vv) : C'(vv);
      sh_neg = uu[C] ^ vv[C] ^ (comp_ff != 2'd0);
   end

   // shoelace term and running sum, both clamped to the signed sum range
   always_comb begin
      if (!acc[AW-1] && (acc > {{(AW-SW){1'b0}}, pqa_pkg::SUM_MAX}))
         term_c = pqa_pkg::SUM_MAX;
      else if (acc[AW-1] && (acc < {{(AW-SW){1'b1}}, pqa_pkg::SUM_MIN}))
         term_c = pqa_pkg::SUM_MIN;
      else
         term_c = acc[SW-1:0];
      sum_wide = {sum_ff[SW-1], sum_ff} + {term_c[SW-1], term_c};
      if (sum_wide[SW] != sum_wide[SW-1])
         sum_new = sum_wide[SW] ? pqa_pkg::SUM_MIN : pqa_pkg::SUM_MAX;
      else
         sum_new = sum_wide[SW-1:0];
   end

   always_comb begin
      area_mag  = sum_ff[SW-1] ? SW'(-sum_ff) : SW'(sum_ff);
      lhs       = {dsq_ff, {pqa_pkg::COS_SHIFT{1'b0}}};
      sharp_now = lhs > acc[2*L+15:0];
      if (area_mag < SW'(min_twice_area)) reason = pqa_pkg::REASON_AREA;
      else if (sharp_ff)                  reason = pqa_pkg::REASON_ANGLE;
      else                                reason = pqa_pkg::REASON_KEPT;
   end

   // next state
   always_comb begin
      state_in  = state_ff;
      issued_in = issued_ff;
      comp_in   = comp_ff;
      unique case (state_ff)
         pqa_pkg::ST_IDLE:     if (req_valid) state_in = pqa_pkg::ST_DISPATCH;
         pqa_pkg::ST_DISPATCH: begin
            case (nj) inside
               pqa_pkg::JOB_EDGE_IN, pqa_pkg::JOB_EDGE_CLOSE: state_in = pqa_pkg::ST_SH;
               pqa_pkg::JOB_ANGLE_IN, pqa_pkg::JOB_ANGLE_LAST,
               pqa_pkg::JOB_ANGLE_FIRST:                      state_in = pqa_pkg::ST_LA;
               default: state_in = last_ff ? pqa_pkg::ST_FINISH : pqa_pkg::ST_IDLE;
            endcase
         end
         pqa_pkg::ST_SH:  if (step_done && comp_ff == 2'd1) state_in = pqa_pkg::ST_SUM;
         pqa_pkg::ST_SUM: state_in = pqa_pkg::ST_DISPATCH;
         pqa_pkg::ST_LA:  if (step_done && comp_ff == 2'd2) state_in = pqa_pkg::ST_LB;
         pqa_pkg::ST_LB:  if (step_done && comp_ff == 2'd2) state_in = pqa_pkg::ST_DOT;
         pqa_pkg::ST_DOT: if (step_done && comp_ff == 2'd2) state_in = pqa_pkg::ST_DSQ;
         pqa_pkg::ST_DSQ: begin
            if (!issued_ff && !dot_pos) state_in = pqa_pkg::ST_DISPATCH;
            else if (step_done)         state_in = pqa_pkg::ST_LL;
         end
         pqa_pkg::ST_LL:     if (step_done) state_in = pqa_pkg::ST_RHS;
         pqa_pkg::ST_RHS:    if (step_done) state_in = pqa_pkg::ST_CMP;
         pqa_pkg::ST_CMP:    state_in = pqa_pkg::ST_DISPATCH;
         pqa_pkg::ST_FINISH: if (rsp_free) state_in = pqa_pkg::ST_IDLE;
         default:            state_in = pqa_pkg::ST_IDLE;
      endcase
      if (state_in != state_ff) begin
         issued_in = 1'b0;
         comp_in   = 2'd0;
      end else if (step_done) begin
         issued_in = 1'b0;
         comp_in   = comp_ff + 2'd1;
      end else if (mctl.start) begin
         issued_in = 1'b1;
      end
   end

   // multiplier commands
   always_comb begin
      mctl  = '0;
      mul_a = '0;
      mul_b = '0;
      unique case (state_ff)
         pqa_pkg::ST_SH: begin
            mctl.start  = !issued_ff;
            mctl.clear  = (comp_ff == 2'd0);
            mctl.negate = sh_neg;
            mctl.digits = DCW'(NDC);
            mul_a       = WA'(u_mag);
            mul_b       = L'(v_mag);
         end
         pqa_pkg::ST_LA: begin
            mctl.start  = !issued_ff;
            mctl.clear  = (comp_ff == 2'd0);
            mctl.digits = DCW'(NDC);
            mul_a       = WA'(da_mag);
            mul_b       = L'(da_mag);
         end
         pqa_pkg::ST_LB: begin
            mctl.start  = !issued_ff;
            mctl.clear  = (comp_ff == 2'd0);
            mctl.digits = DCW'(NDC);
            mul_a       = WA'(db_mag);
            mul_b       = L'(db_mag);
         end
         pqa_pkg::ST_DOT: begin
            mctl.start  = !issued_ff;
            mctl.clear  = (comp_ff == 2'd0);
            mctl.negate = da[C] ^ db[C];
            mctl.digits = DCW'(NDC);
            mul_a       = WA'(da_mag);
            mul_b       = L'(db_mag);
         end
         pqa_pkg::ST_DSQ: begin
            mctl.start  = !issued_ff && dot_pos;
            mctl.clear  = 1'b1;
            mctl.digits = DCW'(NDL);
            mul_a       = WA'(acc[L-1:0]);
            mul_b       = acc[L-1:0];
         end
         pqa_pkg::ST_LL: begin
            mctl.start  = !issued_ff;
            mctl.clear  = 1'b1;
            mctl.digits = DCW'(NDL);
            mul_a       = WA'(la_ff);
            mul_b       = lb_ff;
         end
         pqa_pkg::ST_RHS: begin
            mctl.start  = !issued_ff;
            mctl.clear  = 1'b1;
            mctl.digits = DCW'(NDK);
            mul_a       = acc[WA-1:0];
            mul_b       = L'(angle_cos_sq);
         end
         default: ;
      endcase
   end

   assign req_stall          = (state_ff != pqa_pkg::ST_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_discard        = rsp_discard_ff;
   assign rsp_discard_reason = rsp_reason_ff;
   assign rsp_twice_area     = rsp_area_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pqa_pkg::ST_IDLE;
         issued_ff    <= 1'b0;
         comp_ff      <= 2'd0;
         job_ff       <= pqa_pkg::JOB_NONE;
         count_ff     <= 2'd0;
         sharp_ff     <= 1'b0;
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         last_ff      <= 1'b0;
      end else begin
         state_ff  <= state_in;
         issued_ff <= issued_in;
         comp_ff   <= comp_in;
         if (accept) begin
            last_ff <= req_last_vertex;
            job_ff  <= pqa_pkg::JOB_NONE;
         end
         if (state_ff == pqa_pkg::ST_DISPATCH) begin
            job_ff <= nj;
            if (nj == pqa_pkg::JOB_END && !last_ff && count_ff != 2'd3)
               count_ff <= count_ff + 2'd1;
         end
         if (state_ff == pqa_pkg::ST_SUM) sum_ff <= sum_new;
         if (state_ff == pqa_pkg::ST_CMP && sharp_now) sharp_ff <= 1'b1;
         if (state_ff == pqa_pkg::ST_FINISH && rsp_free) begin
            rsp_valid_ff <= 1'b1;
            sum_ff       <= '0;
            count_ff     <= 2'd0;
            sharp_ff     <= 1'b0;
         end else if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         cur_ff[0] <= req_vertex_x;
         cur_ff[1] <= req_vertex_y;
         cur_ff[2] <= req_vertex_z;
         if (count_ff == 2'd0) begin
            first_ff[0] <= req_vertex_x;
            first_ff[1] <= req_vertex_y;
            first_ff[2] <= req_vertex_z;
         end
         if (count_ff == 2'd1) begin
            second_ff[0] <= req_vertex_x;
            second_ff[1] <= req_vertex_y;
            second_ff[2] <= req_vertex_z;
         end
      end
      if (state_ff == pqa_pkg::ST_DISPATCH && nj == pqa_pkg::JOB_END && !last_ff) begin
         bprev_ff <= prev_ff;
         prev_ff  <= cur_ff;
      end
      if (!issued_ff && comp_ff == 2'd0) begin
         if (state_ff == pqa_pkg::ST_LB)  la_ff  <= acc[L-1:0];
         if (state_ff == pqa_pkg::ST_DOT) lb_ff  <= acc[L-1:0];
         if (state_ff == pqa_pkg::ST_LL)  dsq_ff <= acc[2*L-1:0];
      end
      if (state_ff == pqa_pkg::ST_FINISH && rsp_free) begin
         rsp_discard_ff <= (reason != pqa_pkg::REASON_KEPT);
         rsp_reason_ff  <= reason;
         rsp_area_ff    <= (area_mag > SW'(pqa_pkg::AREA_MAX)) ? pqa_pkg::AREA_MAX
                                                               : area_mag[pqa_pkg::AREA_BITS-1:0];
      end
   end

endmodule

>>> hdl/polygon_area_angle_qualifier.sv
// Top level: register file and vertex sequencer of the polygon area and angle qualifier.
// Each multiply on the shared 8-bit-digit unit runs in steps: issue, one per digit, add.
// Middle vertex: 2 shoelace and 9 angle multiplies of ND_C digits, 2 of ND_L and 1 of ND_K,
//   ND_C = ceil(COORD_BITS/8), ND_L = ceil((2*COORD_BITS+2)/8), ND_K = 2.
// Last vertex adds one closing edge and two wrap-around angles.
// An angle whose dot product is not positive skips dot^2, |a|^2*|b|^2 and cos.
// A verdict beat is registered in FINISH once the output is free; req_stall is high until then.
// Synchronous reset clears the sequencer, polygon state and the output; csr regs take defaults.
module polygon_area_angle_qualifier #(
   parameter int COORD_BITS = pqa_pkg::COORD_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [COORD_BITS-1:0]         req_vertex_x,
   input  logic signed [COORD_BITS-1:0]         req_vertex_y,
   input  logic signed [COORD_BITS-1:0]         req_vertex_z,
   input  logic                                 req_last_vertex,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_discard,
   output logic [1:0]                           rsp_discard_reason,
   output logic [pqa_pkg::AREA_BITS-1:0]        rsp_twice_area,
   input  logic                                 csr_we,
   input  logic [pqa_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [pqa_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);

   // thresholds: twice the minimal area, and cos^2 of the minimal inner angle in Q0.16
   logic [pqa_pkg::CFG_AREA_BITS-1:0] min_area_ff;
   logic [pqa_pkg::CFG_COS_BITS-1:0]  cos_sq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_area_ff <= pqa_pkg::MIN_TWICE_AREA_RESET;
         cos_sq_ff   <= pqa_pkg::ANGLE_COS_SQ_RESET;
      end else if (csr_we) begin
         unique case (pqa_pkg::csr_index_type'(csr_index))
            pqa_pkg::CSR_MIN_TWICE_AREA:
               min_area_ff <= csr_wdata[pqa_pkg::CFG_AREA_BITS-1:0];
            pqa_pkg::CSR_ANGLE_COS_SQ:
               cos_sq_ff   <= csr_wdata[pqa_pkg::CFG_COS_BITS-1:0];
            default: ;
         endcase
      end
   end

   // sequencer owns the vertex store, shoelace sum, sharp flag and the result beat
   pqa_seq #(.COORD_BITS(COORD_BITS)) u_seq (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_vertex_x       (req_vertex_x),
      .req_vertex_y       (req_vertex_y),
      .req_vertex_z       (req_vertex_z),
      .req_last_vertex    (req_last_vertex),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_discard        (rsp_discard),
      .rsp_discard_reason (rsp_discard_reason),
      .rsp_twice_area     (rsp_twice_area),
      .min_twice_area     (min_area_ff),
      .angle_cos_sq       (cos_sq_ff)
   );

endmodule

>>> bench/tb_polygon_area_angle_qualifier.sv
// Testbench of the polygon area and angle qualifier: vertex stimulus, verdict prediction, checks.
module tb_polygon_area_angle_qualifier;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int  CB         = 24;
   localparam int  CYCLE_CAP  = 2000000;
   // The last vertex of a polygon runs longest, so give it room.
   localparam int  DRAIN      = 400;
   localparam int  RAND_ITEMS = 760;
   localparam longint COORD_HI = 64'sd8388607;
   localparam longint COORD_LO = -64'sd8388608;
   localparam longint SHOE_HI  = (64'sd1 <<< 59) - 1;
   localparam longint SHOE_LO  = -(64'sd1 <<< 59);
   localparam longint TWICE_AREA_SAT = (64'sd1 <<< 56) - 1;

   typedef struct {
      longint x;
      longint y;
      longint z;
   } point_type;

   typedef struct {
      bit                            discard;
      pqa_pkg::reason_type           reason;
      logic [pqa_pkg::AREA_BITS-1:0] twice_area;
   } verdict_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                                 req_valid = 1'b0;
   logic                                 req_stall;
   logic signed [CB-1:0]                 req_vertex_x = '0;
   logic signed [CB-1:0]                 req_vertex_y = '0;
   logic signed [CB-1:0]                 req_vertex_z = '0;
   logic                                 req_last_vertex = 1'b0;
   logic                                 rsp_valid;
   logic                                 rsp_stall = 1'b0;
   logic                                 rsp_discard;
   logic [1:0]                           rsp_discard_reason;
   logic [pqa_pkg::AREA_BITS-1:0]        rsp_twice_area;
   logic                                 csr_we = 1'b0;
   logic [pqa_pkg::CSR_INDEX_BITS-1:0]   csr_index = '0;
   logic [pqa_pkg::CSR_DATA_BITS-1:0]    csr_wdata = '0;

   polygon_area_angle_qualifier #(.COORD_BITS(CB)) i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_vertex_x       (req_vertex_x),
      .req_vertex_y       (req_vertex_y),
      .req_vertex_z       (req_vertex_z),
      .req_last_vertex    (req_last_vertex),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_discard        (rsp_discard),
      .rsp_discard_reason (rsp_discard_reason),
      .rsp_twice_area     (rsp_twice_area),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---------------- predictor state: own copy of registers and polygon ----------------
   logic [pqa_pkg::CFG_AREA_BITS-1:0] area_floor = pqa_pkg::MIN_TWICE_AREA_RESET;
   logic [pqa_pkg::CFG_COS_BITS-1:0]  cos_sq_floor = pqa_pkg::ANGLE_COS_SQ_RESET;
   point_type  poly_first, poly_second, poly_prev, poly_prev2;
   longint  shoe_acc;
   int      poly_count;     // saturates at three
   bit      poly_sharp;

   verdict_type verdict_q[$];
   int  fail_count = 0;
   int  cycle_count = 0;
   int  vertex_total = 0;
   bit  no_idle = 1'b0;     // stretches with both sides running flat out

   function automatic longint clamp_shoe(longint v);
      if (v > SHOE_HI) return SHOE_HI;
      if (v < SHOE_LO) return SHOE_LO;
      return v;
   endfunction

   function automatic longint edge_term(point_type p, point_type q);
      return clamp_shoe(p.x * q.y - q.x * p.y);
   endfunction

   // Inner angle at c between edges to p and n; exact integer test, no root.
   function automatic bit corner_too_sharp(point_type p, point_type c, point_type n,
                                           logic [pqa_pkg::CFG_COS_BITS-1:0] cs);
      longint ax, ay, az, bx, by, bz, dot, la, lb;
      logic [127:0] d128, lhs, rhs;
      ax = p.x - c.x; ay = p.y - c.y; az = p.z - c.z;
      bx = n.x - c.x; by = n.y - c.y; bz = n.z - c.z;
      dot = ax * bx + ay * by + az * bz;
      if (dot <= 0) return 1'b0;
      la = ax * ax + ay * ay + az * az;
      lb = bx * bx + by * by + bz * bz;
      d128 = 128'(dot);
      lhs = (d128 * d128) << pqa_pkg::COS_SHIFT;
      rhs = 128'(la) * 128'(lb) * 128'(cs);
      return lhs > rhs;
   endfunction

   task automatic clear_polygon();
      poly_first = '{0, 0, 0};
      poly_second = '{0, 0, 0};
      poly_prev = '{0, 0, 0};
      poly_prev2 = '{0, 0, 0};
      shoe_acc = 0;
      poly_count = 0;
      poly_sharp = 1'b0;
   endtask

   // Advance the polygon by one accepted vertex; a last vertex queues a verdict.
   task automatic predict_vertex(point_type v, bit last);
      int n;
      point_type after_first;
      longint mag;
      verdict_type vd;
      n = poly_count;
      if (n == 0) begin
         poly_first = v;
      end else begin
         shoe_acc = clamp_shoe(shoe_acc + edge_term(poly_prev, v));
         if (n == 1) poly_second = v;
         else if (corner_too_sharp(poly_prev2, poly_prev, v, cos_sq_floor)) poly_sharp = 1'b1;
      end
      if (!last) begin
         poly_prev2 = poly_prev;
         poly_prev = v;
         if (n < 3) poly_count = n + 1;
         return;
      end
      shoe_acc = clamp_shoe(shoe_acc + edge_term(v, poly_first));
      if (n >= 1) begin
         after_first = (n >= 2) ? poly_second : v;
         if (corner_too_sharp(poly_prev, v, poly_first, cos_sq_floor)) poly_sharp = 1'b1;
         if (corner_too_sharp(v, poly_first, after_first, cos_sq_floor)) poly_sharp = 1'b1;
      end
      mag = (shoe_acc < 0) ? -shoe_acc : shoe_acc;
      if (mag < longint'({32'd0, area_floor})) vd.reason = pqa_pkg::REASON_AREA;
      else if (poly_sharp)                     vd.reason = pqa_pkg::REASON_ANGLE;
      else                                     vd.reason = pqa_pkg::REASON_KEPT;
      vd.discard = (vd.reason != pqa_pkg::REASON_KEPT);
      vd.twice_area = (mag > TWICE_AREA_SAT) ? pqa_pkg::AREA_MAX
                                             : mag[pqa_pkg::AREA_BITS-1:0];
      verdict_q = {verdict_q, vd};
      clear_polygon();
   endtask

   // ---------------- driving ----------------
   // Entered at a rising edge; returns at the edge that accepted the beat.
   task automatic send_vertex(longint x, longint y, longint z, bit last);
      int gap;
      point_type v;
      gap = no_idle ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_vertex_x    <= x[CB-1:0];
      req_vertex_y    <= y[CB-1:0];
      req_vertex_z    <= z[CB-1:0];
      req_last_vertex <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      v = '{x, y, z};
      predict_vertex(v, last);
      vertex_total++;
   endtask

   // Let the block drain fully, then write one register.
   task automatic write_reg(pqa_pkg::csr_index_type idx,
                            logic [pqa_pkg::CSR_DATA_BITS-1:0] val);
      req_valid <= 1'b0;
      while (verdict_q.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == pqa_pkg::CSR_MIN_TWICE_AREA) area_floor = val;
      else                                    cos_sq_floor = val[pqa_pkg::CFG_COS_BITS-1:0];
   endtask

   // ---------------- result side: stall draw and checks ----------------
   int rsp_hold = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_CAP) begin
         $display("tb_polygon_area_angle_qualifier: FAIL");
         $finish;
      end
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (verdict_q.size() == 0) begin
               $display("%0t: verdict beat with none expected (area %0d)", $time,
                        rsp_twice_area);
               fail_count++;
            end else begin
               verdict_type e;
               e = verdict_q.pop_front();
               if (rsp_discard !== e.discard) begin
                  $display("%0t: discard exp %0b got %0b", $time, e.discard, rsp_discard);
                  fail_count++;
               end
               if (rsp_discard_reason !== e.reason) begin
                  $display("%0t: reason exp %0d got %0d", $time, e.reason,
                           rsp_discard_reason);
                  fail_count++;
               end
               if (rsp_twice_area !== e.twice_area) begin
                  $display("%0t: twice_area exp %0d got %0d", $time, e.twice_area,
                           rsp_twice_area);
                  fail_count++;
               end
            end
            rsp_hold = no_idle ? 0 : $urandom_range(0, 3);
            rsp_stall <= (rsp_hold != 0);
         end else if (rsp_hold > 0) begin
            rsp_hold--;
            rsp_stall <= (rsp_hold != 0);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // ---------------- tests ----------------
   // Corner values: single vertex, two vertices, area at and below threshold, needle, zero edge, full range, clockwise.
   task automatic test_directed();
      send_vertex(COORD_HI, COORD_LO, COORD_HI, 1'b1);            // single vertex
      send_vertex(0, 0, 0, 1'b0);                                 // two-vertex polygon
      send_vertex(1000, 500, -20, 1'b1);
      send_vertex(0, 0, 0, 1'b0);                                 // twice area == threshold
      send_vertex(160, 0, 0, 1'b0);
      send_vertex(0, 256, 0, 1'b1);
      send_vertex(0, 0, 0, 1'b0);                                 // one below threshold
      send_vertex(159, 0, 0, 1'b0);
      send_vertex(0, 256, 0, 1'b1);
      send_vertex(0, 0, 5, 1'b0);                                 // needle triangle
      send_vertex(100000, 0, 5, 1'b0);
      send_vertex(0, 3000, 5, 1'b1);
      send_vertex(COORD_LO, COORD_LO, COORD_LO, 1'b0);            // full-range square
      send_vertex(COORD_HI, COORD_LO, COORD_HI, 1'b0);
      send_vertex(COORD_HI, COORD_HI, COORD_LO, 1'b0);
      send_vertex(COORD_LO, COORD_HI, COORD_HI, 1'b1);
      send_vertex(10, 10, 0, 1'b0);                               // zero-length edge
      send_vertex(10, 10, 0, 1'b0);
      send_vertex(5000, 10, 0, 1'b0);
      send_vertex(5000, 5000, 0, 1'b1);
      send_vertex(-1, -1, -1, 1'b0);                              // clockwise, negative sum
      send_vertex(-1, 4000, -1, 1'b0);
      send_vertex(4000, -1, -1, 1'b1);
   endtask

   function automatic longint rand_coord();
      return longint'($signed($urandom_range(0, 32'h00FF_FFFF) << 8)) >>> 8;
   endfunction

   // Mostly near-regular polygons with random size and jitter, plus noise polygons.
   task automatic send_random_polygon();
      int n, k, kind;
      longint cx, cy, cz, r, x, y, z;
      real ang;
      kind = $urandom_range(0, 9);
      n = (kind == 0) ? $urandom_range(1, 2) : $urandom_range(3, 8);
      cx = $signed($urandom_range(0, 8388608)) - 4194304;
      cy = $signed($urandom_range(0, 8388608)) - 4194304;
      cz = $signed($urandom_range(0, 8388608)) - 4194304;
      r  = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 200) : $urandom_range(200, 2097152);
      for (k = 0; k < n; k++) begin
         if (kind >= 8) begin
            x = rand_coord(); y = rand_coord(); z = rand_coord();
         end else begin
            ang = 6.283185307 * (k + ($urandom_range(0, 400) / 1000.0)) / n;
            x = cx + longint'($rtoi(r * $cos(ang)));
            y = cy + longint'($rtoi(r * $sin(ang)));
            z = cz + $signed($urandom_range(0, 64)) - 32;
            if (kind == 7 && $urandom_range(0, 2) == 0 && k > 0) begin
               x = req_vertex_x; y = req_vertex_y; z = req_vertex_z;
            end
         end
         send_vertex(x, y, z, k == n - 1);
      end
   endtask

   task automatic test_random_phase(int vertices);
      int target;
      target = vertex_total + vertices;
      while (vertex_total < target) begin
         no_idle = ($urandom_range(0, 5) == 0);
         send_random_polygon();
      end
      no_idle = 1'b0;
   endtask

   // Registers at both extremes, then a random setting, then back to defaults.
   task automatic test_settings();
      write_reg(pqa_pkg::CSR_MIN_TWICE_AREA, 32'd0);
      write_reg(pqa_pkg::CSR_ANGLE_COS_SQ, 32'd0);
      test_random_phase(RAND_ITEMS / 5);
      write_reg(pqa_pkg::CSR_MIN_TWICE_AREA, 32'hFFFF_FFFF);
      write_reg(pqa_pkg::CSR_ANGLE_COS_SQ, 32'h0000_FFFF);
      test_random_phase(RAND_ITEMS / 5);
      write_reg(pqa_pkg::CSR_MIN_TWICE_AREA, 32'd1);
      write_reg(pqa_pkg::CSR_ANGLE_COS_SQ, 32'h0000_FFFF);
      test_random_phase(RAND_ITEMS / 5);
      write_reg(pqa_pkg::CSR_MIN_TWICE_AREA, $urandom_range(0, 32'h00FF_FFFF));
      write_reg(pqa_pkg::CSR_ANGLE_COS_SQ, 32'($urandom_range(0, 65535)));
      test_random_phase(RAND_ITEMS / 5);
      write_reg(pqa_pkg::CSR_MIN_TWICE_AREA, {16'd0, pqa_pkg::MIN_TWICE_AREA_RESET[15:0]});
      write_reg(pqa_pkg::CSR_ANGLE_COS_SQ, {16'd0, pqa_pkg::ANGLE_COS_SQ_RESET});
      test_random_phase(RAND_ITEMS / 5);
   endtask

   initial begin
      clear_polygon();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_phase(RAND_ITEMS / 5);
      test_settings();
      req_valid <= 1'b0;
      while (verdict_q.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb_polygon_area_angle_qualifier: PASS");
      end else begin
         $display("tb_polygon_area_angle_qualifier: FAIL");
      end
      $finish;
   end

endmodule
